FILE: src/weekly_alarm_table_core_defines.svh
// Assertion helpers for the alarm table core.
`ifndef WEEKLY_ALARM_TABLE_CORE_DEFINES_SVH
`define WEEKLY_ALARM_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WAT_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("alarm table assertion failed");
// next-cycle implication
`define WAT_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("alarm table assertion failed");
`else
`define WAT_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define WAT_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

FILE: src/wat_pkg.sv
package wat_pkg;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_ADD    = 2'd1;
	localparam logic [1:0] MODE_UPDATE = 2'd2;
	localparam logic [1:0] MODE_DELETE = 2'd3;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_RELAY  = 2'd1;
	localparam logic [1:0] KIND_REBOOT = 2'd2;

	localparam logic [1:0] ACT_ON     = 2'd0;
	localparam logic [1:0] ACT_OFF    = 2'd1;
	localparam logic [1:0] ACT_TOGGLE = 2'd2;
	localparam logic [1:0] ACT_REBOOT = 2'd3;

	localparam int RESULT_CAP = 8;
	localparam int NW         = $clog2(RESULT_CAP + 1);

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] entry_id;
		logic       enabled;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [6:0] day_mask;
		logic [2:0] weekday;
		logic [1:0] action;
		logic [7:0] relay;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       ok;
		logic [7:0] out_id;
		logic [7:0] out_relay;
		logic [1:0] out_action;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] id;
		logic       en;
		logic [4:0] hr;
		logic [5:0] mn;
		logic [6:0] days;
		logic [1:0] act;
		logic [7:0] rly;
	} entry_t;

	typedef struct packed {
		logic      fire;
		logic      id_hit;
		logic      id_gt;
		out_item_t fired;
	} eval_t;

endpackage

FILE: src/wat_eval.sv
module wat_eval import wat_pkg::*; (
	input  entry_t     ent,
	input  in_item_t   cur,
	input  logic [7:0] maxid,
	output eval_t      ev
);

	logic [6:0] day_bit;

	// weekday 7 shifts out of the mask and matches nothing
	assign day_bit = 7'(8'd1 << cur.weekday);

	always_comb begin
		ev.fire   = ent.en && ((ent.days & day_bit) != 7'd0) &&
			(ent.hr == cur.hour) && (ent.mn == cur.minute);
		ev.id_hit = (ent.id == cur.entry_id);
		ev.id_gt  = (ent.id > maxid);
		ev.fired.ok   = 1'b0;
		ev.fired.last = 1'b0;
		ev.fired.out_id = ent.id;
		if (ent.act == ACT_REBOOT) begin
			ev.fired.kind       = KIND_REBOOT;
			ev.fired.out_relay  = 8'd0;
			ev.fired.out_action = 2'd0;
		end else begin
			ev.fired.kind       = KIND_RELAY;
			ev.fired.out_relay  = ent.rly;
			ev.fired.out_action = ent.act;
		end
	end

endmodule

FILE: src/weekly_alarm_table_core.sv
// channel  | signals                            | dir
// item     | item_valid, item_ready, item       | in
// result   | result_valid, result_ready, result | out
//
// One item at a time. The entry table sits in a one-port-read, one-port-write
// synchronous RAM that is walked one entry per cycle while no fired beat is held
// back. A tick on a repeated minute is dropped in the idle state without a walk.
// Reset clears count, last minute and the other control registers; the RAM
// needs no clearing.
// A fired beat that finds the result register busy holds the walk and rereads that
// entry; the next item is taken while the last beat may still wait.
`include "weekly_alarm_table_core_defines.svh"

module weekly_alarm_table_core import wat_pkg::*; #(
	parameter int MAX_ENTRIES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
	localparam logic [NW-1:0] CAP_CNT = NW'(RESULT_CAP);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_SHIFT, ST_WRITE, ST_RESP, ST_FLUSH
	} state_t;

	state_t          state_q;
	in_item_t        item_q;
	logic [CW-1:0]   count_q;
	logic [7:0]      last_min_q;
	logic [CW-1:0]   rd_idx_q;
	logic            vld_s1;
	logic [CW-1:0]   idx_s1;
	entry_t          rd_data_s1;
	logic [7:0]      maxid_q;
	logic [CW-1:0]   pos_q;
	logic [NW-1:0]   n_q;
	logic            pend_valid_q;
	out_item_t       pend_q;
	logic            res_ok_q;
	logic [7:0]      res_id_q;
	logic            result_valid_q;
	out_item_t       result_q;

	entry_t          mem [MAX_ENTRIES];
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	entry_t          mem_wdata;
	logic [CW-1:0]   shift_dst;
	logic [7:0]      new_id;

	logic            rd_more;
	logic            scan_end;
	logic            can_push;
	eval_t           ev;

	logic            tick_hit;
	logic            tick_stall;
	logic            tick_take;
	logic            del_hit;
	logic            push_res;
	out_item_t       push_data;
	logic            add_wr;

	wat_eval u_eval (
		.ent   (rd_data_s1),
		.cur   (item_q),
		.maxid (maxid_q),
		.ev    (ev)
	);

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign rd_more  = (rd_idx_q < count_q);
	assign scan_end = !vld_s1 && !rd_more;
	assign can_push = !result_valid_q || result_ready;

	assign shift_dst = CW'(idx_s1 - 1'b1);
	assign new_id    = (item_q.mode == MODE_ADD) ? 8'(maxid_q + 8'd1) : item_q.entry_id;

	assign tick_hit   = (item_q.mode == MODE_TICK) && vld_s1 && ev.fire && (n_q < CAP_CNT);
	// result register still holds an earlier beat: replay this entry once it drains
	assign tick_stall = tick_hit && pend_valid_q && !can_push;
	assign tick_take  = tick_hit && !tick_stall;
	assign del_hit    = (item_q.mode == MODE_DELETE) && vld_s1 && ev.id_hit;
	assign add_wr     = (state_q == ST_WRITE) && (item_q.mode == MODE_ADD);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = shift_dst[AW-1:0];
		mem_wdata = rd_data_s1;
		if (state_q == ST_SHIFT) begin
			mem_we = vld_s1;
		end else if (state_q == ST_WRITE) begin
			mem_we    = 1'b1;
			mem_waddr = (item_q.mode == MODE_ADD) ? count_q[AW-1:0] : pos_q[AW-1:0];
			mem_wdata = '{id: new_id, en: item_q.enabled, hr: item_q.hour,
				mn: item_q.minute, days: item_q.day_mask, act: item_q.action,
				rly: item_q.relay};
		end
	end

	always_comb begin
		push_res  = 1'b0;
		push_data = pend_q;
		case (state_q)
			ST_SCAN: push_res = tick_take && pend_valid_q;
			ST_RESP: begin
				push_res  = can_push;
				push_data = '{kind: KIND_STATUS, ok: res_ok_q, out_id: res_id_q,
					out_relay: 8'd0, out_action: 2'd0, last: 1'b1};
			end
			ST_FLUSH: begin
				push_res       = pend_valid_q && can_push;
				push_data.last = 1'b1;
			end
			default: push_res = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			item_q         <= '0;
			count_q        <= '0;
			last_min_q     <= 8'hFF;
			rd_idx_q       <= '0;
			vld_s1         <= 1'b0;
			idx_s1         <= '0;
			maxid_q        <= '0;
			pos_q          <= '0;
			n_q            <= '0;
			pend_valid_q   <= 1'b0;
			pend_q         <= '0;
			res_ok_q       <= 1'b0;
			res_id_q       <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (push_res) begin
				result_q       <= push_data;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						item_q   <= item;
						rd_idx_q <= '0;
						vld_s1   <= 1'b0;
						maxid_q  <= '0;
						n_q      <= '0;
						case (item.mode)
							MODE_TICK: begin
								if ({2'b00, item.minute} != last_min_q) begin
									last_min_q <= {2'b00, item.minute};
									state_q    <= ST_SCAN;
								end
							end
							MODE_ADD: begin
								if (count_q >= MAX_CNT) begin
									res_ok_q <= 1'b0;
									res_id_q <= '0;
									state_q  <= ST_RESP;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: state_q <= ST_SCAN;
						endcase
					end
				end
				ST_SCAN: begin
					if (tick_stall) begin
						rd_idx_q <= idx_s1;
						vld_s1   <= 1'b0;
					end else if (del_hit) begin
						rd_idx_q <= CW'(idx_s1 + 1'b1);
						vld_s1   <= 1'b0;
					end else begin
						vld_s1 <= rd_more;
						if (rd_more) begin
							idx_s1   <= rd_idx_q;
							rd_idx_q <= CW'(rd_idx_q + 1'b1);
						end
					end
					case (item_q.mode)
						MODE_TICK: begin
							if (tick_take) begin
								pend_q       <= ev.fired;
								pend_valid_q <= 1'b1;
								n_q          <= NW'(n_q + 1'b1);
							end else if (scan_end) begin
								state_q <= ST_FLUSH;
							end
						end
						MODE_ADD: begin
							if (vld_s1 && ev.id_gt) begin
								maxid_q <= rd_data_s1.id;
							end else if (scan_end) begin
								state_q <= ST_WRITE;
							end
						end
						MODE_UPDATE: begin
							if (vld_s1 && ev.id_hit) begin
								pos_q   <= idx_s1;
								state_q <= ST_WRITE;
							end else if (scan_end) begin
								res_ok_q <= 1'b0;
								res_id_q <= item_q.entry_id;
								state_q  <= ST_RESP;
							end
						end
						default: begin
							if (del_hit) begin
								res_ok_q <= 1'b1;
								res_id_q <= item_q.entry_id;
								state_q  <= ST_SHIFT;
							end else if (scan_end) begin
								res_ok_q <= 1'b0;
								res_id_q <= item_q.entry_id;
								state_q  <= ST_RESP;
							end
						end
					endcase
				end
				ST_SHIFT: begin
					// read entry i, write it back at i-1
					vld_s1 <= rd_more;
					if (rd_more) begin
						idx_s1   <= rd_idx_q;
						rd_idx_q <= CW'(rd_idx_q + 1'b1);
					end
					if (scan_end) begin
						count_q <= CW'(count_q - 1'b1);
						state_q <= ST_RESP;
					end
				end
				ST_WRITE: begin
					if (item_q.mode == MODE_ADD) begin
						count_q <= CW'(count_q + 1'b1);
					end
					res_ok_q <= 1'b1;
					res_id_q <= new_id;
					state_q  <= ST_RESP;
				end
				ST_RESP: begin
					if (can_push) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (can_push) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`WAT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= MAX_CNT)
	`WAT_ASSERT_IMP(a_idle_no_pend, clk, arst_n, state_q == ST_IDLE, !pend_valid_q)
	`WAT_ASSERT_IMP(a_tick_no_write, clk, arst_n, mem_we, item_q.mode != MODE_TICK)
	`WAT_ASSERT_IMP(a_fire_cap, clk, arst_n, 1'b1, n_q <= CAP_CNT)
	`WAT_ASSERT_NXT(a_add_grows, clk, arst_n, add_wr, count_q == $past(count_q) + 1'b1)

endmodule

FILE: tb/weekly_alarm_table_core_test.sv
module weekly_alarm_table_core_test import wat_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 8;
	localparam int CHURN_ITEMS  = 160;
	localparam int RANDOM_ITEMS = 220;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;

	weekly_alarm_table_core #(.MAX_ENTRIES(TABLE_DEPTH)) DUT (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result
	);

	// Tracks the alarm table and the result beats each item should produce.
	class alarm_table_tracker;
		entry_t    tbl[TABLE_DEPTH];
		int        entry_count;
		logic [7:0] last_min;
		out_item_t pending_results[$];
		int        errors;

		function new();
			entry_count = 0;
			last_min = 8'hFF;
			errors = 0;
		endfunction

		function entry_t make_entry(in_item_t it, logic [7:0] id);
			entry_t e;
			e.id = id;
			e.en = it.enabled;
			e.hr = it.hour;
			e.mn = it.minute;
			e.days = it.day_mask;
			e.act = it.action;
			e.rly = it.relay;
			return e;
		endfunction

		function int find_id(logic [7:0] id);
			for (int i = 0; i < entry_count; i++)
				if (tbl[i].id == id) return i;
			return -1;
		endfunction

		function logic [7:0] max_id();
			logic [7:0] top;
			top = 8'd0;
			for (int i = 0; i < entry_count; i++)
				if (tbl[i].id > top) top = tbl[i].id;
			return top;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void note_beat(out_item_t r);
			pending_results = {pending_results, r};
		endfunction

		function void apply_item(in_item_t it);
			out_item_t r;
			out_item_t held;
			bit        have;
			int        p;
			logic [7:0] day_bit;
			int        fired;
			r = '0;
			case (it.mode)
				MODE_TICK: begin
					if ({2'b00, it.minute} == last_min) return;
					last_min = {2'b00, it.minute};
					// weekday 7 lands on bit 7, outside the 7-bit mask
					day_bit = 8'd1 << it.weekday;
					have = 0;
					held = '0;
					fired = 0;
					for (int i = 0; i < entry_count; i++) begin
						if (tbl[i].en && (tbl[i].days & day_bit[6:0]) != 7'd0 &&
								tbl[i].hr == it.hour && tbl[i].mn == it.minute &&
								fired < RESULT_CAP) begin
							if (have) note_beat(held);
							held = '0;
							held.out_id = tbl[i].id;
							if (tbl[i].act == ACT_REBOOT) begin
								held.kind = KIND_REBOOT;
							end else begin
								held.kind = KIND_RELAY;
								held.out_relay = tbl[i].rly;
								held.out_action = tbl[i].act;
							end
							have = 1;
							fired++;
						end
					end
					if (have) begin
						held.last = 1'b1;
						note_beat(held);
					end
				end
				MODE_ADD: begin
					r.kind = KIND_STATUS;
					if (entry_count < TABLE_DEPTH) begin
						r.out_id = max_id() + 8'd1;
						r.ok = 1'b1;
						tbl[entry_count] = make_entry(it, r.out_id);
						entry_count++;
					end
					r.last = 1'b1;
					note_beat(r);
				end
				MODE_UPDATE: begin
					p = find_id(it.entry_id);
					if (p >= 0) tbl[p] = make_entry(it, it.entry_id);
					r.kind = KIND_STATUS;
					r.ok = (p >= 0);
					r.out_id = it.entry_id;
					r.last = 1'b1;
					note_beat(r);
				end
				default: begin
					p = find_id(it.entry_id);
					if (p >= 0) begin
						for (int i = p; i < entry_count - 1; i++) tbl[i] = tbl[i + 1];
						entry_count--;
					end
					r.kind = KIND_STATUS;
					r.ok = (p >= 0);
					r.out_id = it.entry_id;
					r.last = 1'b1;
					note_beat(r);
				end
			endcase
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			cmp_field("kind", 8'(want.kind), 8'(got.kind));
			cmp_field("ok", 8'(want.ok), 8'(got.ok));
			cmp_field("out_id", want.out_id, got.out_id);
			cmp_field("out_relay", want.out_relay, got.out_relay);
			cmp_field("out_action", 8'(want.out_action), 8'(got.out_action));
			cmp_field("last", 8'(want.last), 8'(got.last));
		endfunction
	endclass

	alarm_table_tracker alarm_sb;

	bit         steady_in;
	bit         steady_out;
	logic [4:0] pool_hr[3];
	logic [5:0] pool_mn[3];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic in_item_t mk(logic [1:0] op, logic [7:0] id, logic en, logic [4:0] hr,
			logic [5:0] mn, logic [6:0] mask, logic [2:0] wd, logic [1:0] act, logic [7:0] rly);
		in_item_t it;
		it.mode = op;
		it.entry_id = id;
		it.enabled = en;
		it.hour = hr;
		it.minute = mn;
		it.day_mask = mask;
		it.weekday = wd;
		it.action = act;
		it.relay = rly;
		return it;
	endfunction

	// Random entry content; times mostly from a small shared pool so ticks hit
	// several entries at once.
	function automatic in_item_t entry_fields(logic [1:0] op);
		in_item_t it;
		int p;
		it.mode = op;
		it.entry_id = 8'($urandom);
		it.enabled = ($urandom_range(0, 9) != 0);
		p = $urandom_range(0, 3);
		if (p < 3) begin
			it.hour = pool_hr[p];
			it.minute = pool_mn[p];
		end else begin
			it.hour = 5'($urandom);
			it.minute = 6'($urandom);
		end
		it.day_mask = 7'($urandom);
		it.weekday = 3'($urandom);
		it.action = 2'($urandom);
		it.relay = 8'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] existing_id(bit first);
		if (alarm_sb.entry_count == 0 || $urandom_range(0, 6) == 0) return 8'($urandom);
		if (first) return alarm_sb.tbl[0].id;
		return alarm_sb.tbl[$urandom_range(0, alarm_sb.entry_count - 1)].id;
	endfunction

	function automatic in_item_t tick_item();
		in_item_t it;
		entry_t   e;
		it = entry_fields(MODE_TICK);
		if (alarm_sb.entry_count > 0 && $urandom_range(0, 3) != 0) begin
			e = alarm_sb.tbl[$urandom_range(0, alarm_sb.entry_count - 1)];
			it.hour = e.hr;
			it.minute = e.mn;
			it.weekday = 3'($urandom_range(0, 6));
			for (int k = 0; k < 8 && !e.days[it.weekday]; k++)
				it.weekday = 3'($urandom_range(0, 6));
		end
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int w;
		w = $urandom_range(0, 99);
		if (w < 10) begin
			it = entry_fields(2'($urandom));
			it.hour = 5'($urandom);
			it.minute = 6'($urandom);
		end else if (w < 37) begin
			it = tick_item();
		end else if (w < 64) begin
			it = entry_fields(MODE_ADD);
		end else if (w < 78) begin
			it = entry_fields(MODE_UPDATE);
			it.entry_id = existing_id(0);
		end else begin
			it = entry_fields(MODE_DELETE);
			it.entry_id = existing_id(1'($urandom_range(0, 1)));
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0) steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = it;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		alarm_sb.apply_item(it);
		@(negedge clk);
	endtask

	// result sink: random stall before each beat
	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) steady_out = !steady_out;
			stall = steady_out ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				result_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready = 1'b1;
			do @(posedge clk); while (!result_valid);
			alarm_sb.check_result(result);
			@(negedge clk);
		end
	end

	initial begin
		in_item_t it;
		int done;
		int guard;
		alarm_sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		steady_in = 0;
		steady_out = 0;
		pool_hr[0] = 5'($urandom);
		pool_hr[1] = 5'($urandom);
		pool_hr[2] = 5'($urandom);
		pool_mn[0] = 6'($urandom_range(0, 20));
		pool_mn[1] = 6'($urandom_range(21, 41));
		pool_mn[2] = 6'($urandom_range(42, 63));
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table: first tick, unknown ids at both ends of the range
		send_item(mk(MODE_TICK, 8'd0, 1'b0, 5'd0, 6'd0, 7'd0, 3'd0, ACT_ON, 8'd0));
		send_item(mk(MODE_UPDATE, 8'd0, 1'b1, 5'd5, 6'd10, 7'h7F, 3'd0, ACT_ON, 8'd1));
		send_item(mk(MODE_DELETE, 8'hFF, 1'b1, 5'd0, 6'd0, 7'd0, 3'd0, ACT_ON, 8'd0));
		// fill the table with entries sharing one time, every action
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_item(mk(MODE_ADD, 8'($urandom), 1'b1, 5'd23, 6'd59, 7'h7F, 3'd0,
				2'(i), (i == 0) ? 8'd0 : (i == 1) ? 8'hFF : 8'(i * 37)));
		send_item(mk(MODE_ADD, 8'hFF, 1'b1, 5'd31, 6'd63, 7'h7F, 3'd7, ACT_REBOOT, 8'hFF));
		send_item(mk(MODE_TICK, 8'd0, 1'b0, 5'd23, 6'd59, 7'd0, 3'd6, ACT_ON, 8'd0));
		send_item(mk(MODE_TICK, 8'd0, 1'b0, 5'd23, 6'd59, 7'd0, 3'd6, ACT_ON, 8'd0));
		send_item(mk(MODE_TICK, 8'd0, 1'b0, 5'd23, 6'd58, 7'd0, 3'd7, ACT_ON, 8'd0));
		send_item(mk(MODE_UPDATE, 8'd3, 1'b0, 5'd31, 6'd63, 7'h01, 3'd0, ACT_REBOOT, 8'hFF));
		send_item(mk(MODE_TICK, 8'd0, 1'b0, 5'd23, 6'd59, 7'd0, 3'd0, ACT_ON, 8'd0));
		send_item(mk(MODE_UPDATE, 8'd3, 1'b1, 5'd31, 6'd63, 7'h01, 3'd0, ACT_REBOOT, 8'hFF));
		send_item(mk(MODE_TICK, 8'hFF, 1'b1, 5'd31, 6'd63, 7'h7F, 3'd0, ACT_REBOOT, 8'hFF));
		// first, last and middle deletes
		send_item(mk(MODE_DELETE, 8'd1, 1'b0, 5'd0, 6'd0, 7'd0, 3'd0, ACT_ON, 8'd0));
		send_item(mk(MODE_DELETE, 8'd8, 1'b0, 5'd0, 6'd0, 7'd0, 3'd0, ACT_ON, 8'd0));
		send_item(mk(MODE_DELETE, 8'd4, 1'b0, 5'd0, 6'd0, 7'd0, 3'd0, ACT_ON, 8'd0));
		send_item(mk(MODE_ADD, 8'd0, 1'b1, 5'd23, 6'd59, 7'h7F, 3'd0, ACT_TOGGLE, 8'h5A));
		send_item(mk(MODE_TICK, 8'd0, 1'b0, 5'd23, 6'd59, 7'd0, 3'd1, ACT_ON, 8'd0));
		send_item(mk(MODE_UPDATE, 8'd200, 1'b1, 5'd1, 6'd2, 7'h55, 3'd0, ACT_OFF, 8'd9));

		// churn the table (add, drop the oldest) so ids climb well past the table depth
		guard = 0;
		while (guard < CHURN_ITEMS) begin
			guard++;
			if ($urandom_range(0, 9) == 0) begin
				it = tick_item();
			end else if (alarm_sb.entry_count >= 6 ||
					(alarm_sb.entry_count > 1 && $urandom_range(0, 2) == 0)) begin
				it = entry_fields(MODE_DELETE);
				it.entry_id = alarm_sb.tbl[0].id;
			end else begin
				it = entry_fields(MODE_ADD);
			end
			send_item(it);
		end

		// mixed traffic; repeated-minute ticks are ignored by the block, not counted
		done = 0;
		while (done < RANDOM_ITEMS) begin
			it = random_item();
			if (!(it.mode == MODE_TICK && {2'b00, it.minute} == alarm_sb.last_min)) done++;
			send_item(it);
		end
		item_valid = 1'b0;

		while (alarm_sb.outstanding() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (alarm_sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/wat_pkg.sv
src/wat_eval.sv
src/weekly_alarm_table_core.sv
tb/weekly_alarm_table_core_test.sv
